FILE: src/encoder_menu_setpoint_controller_assert.svh
// ----------------------------------------------------------------------------
// encoder_menu_setpoint_controller_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ENCODER_MENU_SETPOINT_CONTROLLER_ASSERT_SVH
`define ENCODER_MENU_SETPOINT_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define EMSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define EMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/emsc_pkg.sv
// ----------------------------------------------------------------------------
// emsc_pkg
// Types and constants of the encoder menu setpoint controller.
// ----------------------------------------------------------------------------
package emsc_pkg;

  localparam int unsigned STEP_W = 8;
  localparam int unsigned SP_W   = 12;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 2;

  localparam logic [STEP_W-1:0] FINE_STEP_RST   = 8'd5;
  localparam logic [STEP_W-1:0] COARSE_STEP_RST = 8'd10;
  localparam logic [SP_W-1:0]   MAX_SP_RST      = 12'd4095;

  // event codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LEFT  = 3'd0,
    CMD_RIGHT = 3'd1,
    CMD_SHORT = 3'd2,
    CMD_LONG  = 3'd3,
    CMD_TEMP  = 3'd4
  } cmd_t;

  // config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_FINE_STEP   = 2'd0,
    REG_COARSE_STEP = 2'd1,
    REG_MAX_SP      = 2'd2
  } reg_idx_t;

  // mode codes as seen on the port
  localparam logic [MODE_W-1:0] MODE_READOUT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MENU    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAULT   = 2'd2;

  typedef enum logic [2:0] {
    ST_READOUT = 3'b001,
    ST_MENU    = 3'b010,
    ST_FAULT   = 3'b100
  } state_t;

  function automatic logic [MODE_W-1:0] mode_code(input state_t st);
    logic [MODE_W-1:0] code;
    unique case (st)
      ST_MENU:  code = MODE_MENU;
      ST_FAULT: code = MODE_FAULT;
      default:  code = MODE_READOUT;
    endcase
    return code;
  endfunction

endpackage

FILE: src/encoder_menu_setpoint_controller.sv
// ----------------------------------------------------------------------------
// encoder_menu_setpoint_controller
// Encoder event decoder with start/stop menu, step choice, saturating PWM
// setpoint and overtemperature lockout.
// ----------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+------------------------------------
// in       | in  | in_valid / in_stall  | cmd, overheated
// out      | out | out_valid / out_stall| mode, setpoint, drive_value,
//          |     |                      | drive_write, is_stopped, cursor,
//          |     |                      | coarse_mode, is_locked
// cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; an accepted
// request passes the input register, then the result register (state updated with the result).
// Reset (rst, synchronous) restores modes, flags, setpoint and config values.
// A stalled result holds the output register; the input register is still
// free to take one request, after which in_stall rises.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module encoder_menu_setpoint_controller
  import emsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic              overheated,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MODE_W-1:0] mode,
  output logic [SP_W-1:0]   setpoint,
  output logic [SP_W-1:0]   drive_value,
  output logic              drive_write,
  output logic              is_stopped,
  output logic              cursor,
  output logic              coarse_mode,
  output logic              is_locked,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SP_W-1:0]   cfg_data
);

  logic [STEP_W-1:0] fine_step;
  logic [STEP_W-1:0] coarse_step;
  logic [SP_W-1:0]   max_sp;

  logic              req_valid;
  cmd_t              req_cmd;
  logic              req_hot;

  state_t            state, state_next;
  state_t            ret_state, ret_state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic              stopped, stopped_next;
  logic              cur, cur_next;
  logic              coarse, coarse_next;
  logic              lock, lock_next;
  logic              wrote;

  logic              advance;
  logic [STEP_W:0]   inc;
  logic [SP_W-1:0]   inc_ext;
  logic [SP_W-1:0]   headroom;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_step   <= FINE_STEP_RST;
      coarse_step <= COARSE_STEP_RST;
      max_sp      <= MAX_SP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FINE_STEP:   fine_step   <= cfg_data[STEP_W-1:0];
        REG_COARSE_STEP: coarse_step <= cfg_data[STEP_W-1:0];
        REG_MAX_SP:      max_sp      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      req_cmd <= cmd_t'(cmd);
      req_hot <= overheated;
    end
  end

  assign inc      = {1'b0, (coarse ? coarse_step : fine_step)} + {{STEP_W{1'b0}}, 1'b1};
  assign inc_ext  = {{(SP_W-STEP_W-1){1'b0}}, inc};
  assign headroom = max_sp - sp;

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    sp_next        = sp;
    stopped_next   = stopped;
    cur_next       = cur;
    coarse_next    = coarse;
    lock_next      = lock;
    wrote          = 1'b0;
    if (req_cmd == CMD_TEMP) begin
      if (req_hot) begin
        ret_state_next = state;
        state_next     = ST_FAULT;
        lock_next      = 1'b1;
      end else begin
        state_next = ST_READOUT;
        lock_next  = 1'b0;
      end
    end else if (req_cmd <= CMD_LONG && !lock) begin
      unique case (state)
        ST_READOUT: begin
          unique case (req_cmd)
            CMD_LEFT: begin
              if (sp != '0 && !stopped) begin
                sp_next = (sp > inc_ext) ? sp - inc_ext : '0;
                wrote   = 1'b1;
              end
            end
            CMD_RIGHT: begin
              if (sp < max_sp && !stopped) begin
                sp_next = (headroom > inc_ext) ? sp + inc_ext : max_sp;
                wrote   = 1'b1;
              end
            end
            CMD_SHORT: begin
              ret_state_next = state;
              state_next     = ST_MENU;
              cur_next       = 1'b0;
            end
            CMD_LONG: coarse_next = !coarse;
            default: ;
          endcase
        end
        ST_MENU: begin
          unique case (req_cmd)
            CMD_LEFT:  cur_next = 1'b0;
            CMD_RIGHT: cur_next = 1'b1;
            CMD_SHORT: begin
              stopped_next = cur;
              wrote        = 1'b1;
              state_next   = ret_state;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= ST_READOUT;
      ret_state <= ST_READOUT;
      sp        <= '0;
      stopped   <= 1'b0;
      cur       <= 1'b0;
      coarse    <= 1'b0;
      lock      <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
      if (req_valid) begin
        state     <= state_next;
        ret_state <= ret_state_next;
        sp        <= sp_next;
        stopped   <= stopped_next;
        cur       <= cur_next;
        coarse    <= coarse_next;
        lock      <= lock_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      mode        <= mode_code(state_next);
      setpoint    <= sp_next;
      drive_value <= stopped_next ? '0 : sp_next;
      drive_write <= wrote;
      is_stopped  <= stopped_next;
      cursor      <= cur_next;
      coarse_mode <= coarse_next;
      is_locked   <= lock_next;
    end
  end

endmodule

FILE: src/emsc_checker.sv
// ----------------------------------------------------------------------------
// emsc_checker
// Port-level checks of the encoder menu setpoint controller.
// ----------------------------------------------------------------------------
`include "encoder_menu_setpoint_controller_assert.svh"

module emsc_checker
  import emsc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MODE_W-1:0] mode,
  input logic [SP_W-1:0]   setpoint,
  input logic [SP_W-1:0]   drive_value,
  input logic              drive_write,
  input logic              is_stopped,
  input logic              is_locked
);

  // lockout and fault mode go together
  `EMSC_ASSERT_NOW(a_lock_fault, out_valid, is_locked == (mode == MODE_FAULT), "lock/mode mismatch")

  // compare value follows stop flag and setpoint
  `EMSC_ASSERT_NOW(a_drive_val, out_valid, drive_value == (is_stopped ? '0 : setpoint), "bad drive")

  // every compare rewrite leaves the block in readout
  `EMSC_ASSERT_NOW(a_write_mode, out_valid && drive_write, mode == MODE_READOUT, "write outside readout")

  // stalled result stays presented
  `EMSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

endmodule

bind encoder_menu_setpoint_controller emsc_checker u_emsc_checker (.*);

FILE: test/encoder_menu_setpoint_controller_tb.sv
// ----------------------------------------------------------------------------
// encoder_menu_setpoint_controller_tb
// Self-checking bench for the encoder menu setpoint controller. Encoder turns,
// presses and temperature reports are sent over the request channel. Random
// idle bursts are placed on the request side and random stalls on the result
// side. A behavioral model of the mode, setpoint, step and lockout logic
// predicts every result, and each result is compared against the oldest
// prediction. Directed tests cover turns, the start/stop menu, fault lockout
// and saturation. Random traffic then runs under several register settings,
// the extreme values among them.
// ----------------------------------------------------------------------------
module encoder_menu_setpoint_controller_tb;
  import emsc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SP_W-1:0]   setpoint;
    logic [SP_W-1:0]   drive;
    logic              wr;
    logic              stopped;
    logic              cur;
    logic              coarse;
    logic              locked;
  } ctrl_view_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd = '0;
  logic              overheated = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [MODE_W-1:0] mode;
  logic [SP_W-1:0]   setpoint;
  logic [SP_W-1:0]   drive_value;
  logic              drive_write;
  logic              is_stopped;
  logic              cursor;
  logic              coarse_mode;
  logic              is_locked;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [SP_W-1:0]   cfg_data = '0;

  // model state
  logic [MODE_W-1:0] st_mode = MODE_READOUT;
  logic [MODE_W-1:0] st_ret = MODE_READOUT;
  logic [SP_W-1:0]   st_sp = '0;
  logic              st_stopped = 1'b0;
  logic              st_cur = 1'b0;
  logic              st_coarse = 1'b0;
  logic              st_locked = 1'b0;
  logic [STEP_W-1:0] fine_m1 = FINE_STEP_RST;
  logic [STEP_W-1:0] coarse_m1 = COARSE_STEP_RST;
  logic [SP_W-1:0]   sp_max = MAX_SP_RST;

  ctrl_view_t  pending_views[$];
  bit          in_gap_on = 1'b1;
  bit          stall_on = 1'b0;
  int unsigned stall_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned events_sent = 0;
  int unsigned effective_events = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned compare_writes = 0;
  int unsigned fault_reports = 0;

  encoder_menu_setpoint_controller dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .overheated  (overheated),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode        (mode),
    .setpoint    (setpoint),
    .drive_value (drive_value),
    .drive_write (drive_write),
    .is_stopped  (is_stopped),
    .cursor      (cursor),
    .coarse_mode (coarse_mode),
    .is_locked   (is_locked),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial forever #2 clk = ~clk;

  function automatic string format_view(input ctrl_view_t v);
    return $sformatf("mode=%0d sp=%0d drive=%0d wr=%b stop=%b cur=%b coarse=%b lock=%b",
                     v.mode, v.setpoint, v.drive, v.wr, v.stopped, v.cur, v.coarse,
                     v.locked);
  endfunction

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", what);
  endfunction

  // advance the controller model by one event and return the expected result
  function automatic ctrl_view_t apply_event(input logic [CMD_W-1:0] c, input logic hot);
    ctrl_view_t v;
    int         step;
    logic       wrote;
    logic [19:0] prior;
    wrote = 1'b0;
    step  = int'(st_coarse ? coarse_m1 : fine_m1) + 1;
    prior = {st_mode, st_ret, st_sp, st_stopped, st_cur, st_coarse, st_locked};
    if (c == CMD_TEMP) begin
      if (hot) begin
        st_ret    = st_mode;
        st_mode   = MODE_FAULT;
        st_locked = 1'b1;
      end else begin
        st_mode   = MODE_READOUT;
        st_locked = 1'b0;
      end
    end else if (c <= CMD_LONG && !st_locked) begin
      if (st_mode == MODE_READOUT) begin
        case (c)
          CMD_LEFT: begin
            if (st_sp != 0 && !st_stopped) begin
              st_sp = (int'(st_sp) > step) ? SP_W'(int'(st_sp) - step) : '0;
              wrote = 1'b1;
            end
          end
          CMD_RIGHT: begin
            if (st_sp < sp_max && !st_stopped) begin
              st_sp = (int'(sp_max) - int'(st_sp) > step) ? SP_W'(int'(st_sp) + step)
                                                           : sp_max;
              wrote = 1'b1;
            end
          end
          CMD_SHORT: begin
            st_ret  = st_mode;
            st_mode = MODE_MENU;
            st_cur  = 1'b0;
          end
          default: st_coarse = ~st_coarse;
        endcase
      end else if (st_mode == MODE_MENU) begin
        case (c)
          CMD_LEFT:  st_cur = 1'b0;
          CMD_RIGHT: st_cur = 1'b1;
          CMD_SHORT: begin
            st_stopped = st_cur;
            wrote      = 1'b1;
            st_mode    = st_ret;
          end
          default: ;
        endcase
      end
    end
    if (wrote || prior != {st_mode, st_ret, st_sp, st_stopped, st_cur, st_coarse, st_locked})
      effective_events++;
    v.mode     = st_mode;
    v.setpoint = st_sp;
    v.drive    = st_stopped ? '0 : st_sp;
    v.wr       = wrote;
    v.stopped  = st_stopped;
    v.cur      = st_cur;
    v.coarse   = st_coarse;
    v.locked   = st_locked;
    return v;
  endfunction

  task automatic send_event(input logic [CMD_W-1:0] c, input logic hot);
    ctrl_view_t v;
    if (in_gap_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    overheated <= hot;
    do @(posedge clk); while (in_stall !== 1'b0);
    v = apply_event(c, hot);
    pending_views.push_back(v);
    events_sent++;
    if (v.wr) compare_writes++;
    if (c == CMD_TEMP && hot) fault_reports++;
  endtask

  // drains the block before writing; upper data bits of step writes are junk
  task automatic set_config(input logic [STEP_W-1:0] f, input logic [STEP_W-1:0] c,
                            input logic [SP_W-1:0] m);
    logic [IDX_W-1:0] idx [4];
    logic [SP_W-1:0]  dat [4];
    logic [3:0]       pad;
    idx[0] = REG_FINE_STEP;
    idx[1] = REG_COARSE_STEP;
    idx[2] = REG_MAX_SP;
    idx[3] = REG_UNUSED;
    pad    = 4'($urandom());
    dat[0] = {pad, f};
    pad    = 4'($urandom());
    dat[1] = {pad, c};
    dat[2] = m;
    dat[3] = SP_W'($urandom());
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      reg_writes++;
      case (idx[k])
        REG_FINE_STEP:   fine_m1 = dat[k][STEP_W-1:0];
        REG_COARSE_STEP: coarse_m1 = dat[k][STEP_W-1:0];
        REG_MAX_SP:      sp_max = dat[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_readout_turns();
    send_event(CMD_LEFT, 1'b0);
    send_event(CMD_RIGHT, 1'b1);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_LONG, 1'b0);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_LEFT, 1'b1);
    send_event(CMD_RSVD_5, 1'b1);
    send_event(CMD_RSVD_7, 1'b0);
  endtask

  task automatic test_menu_start_stop();
    send_event(CMD_SHORT, 1'b0);
    send_event(CMD_LEFT, 1'b0);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_RIGHT, 1'b1);
    send_event(CMD_SHORT, 1'b0);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_LONG, 1'b0);
    send_event(CMD_SHORT, 1'b0);
    send_event(CMD_LONG, 1'b0);
    send_event(CMD_LEFT, 1'b0);
    send_event(CMD_SHORT, 1'b0);
  endtask

  task automatic test_fault_lockout();
    send_event(CMD_SHORT, 1'b0);
    send_event(CMD_TEMP, 1'b1);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_LONG, 1'b1);
    send_event(CMD_TEMP, 1'b1);
    send_event(CMD_TEMP, 1'b0);
    send_event(CMD_TEMP, 1'b0);
  endtask

  task automatic test_setpoint_limits();
    set_config(8'd255, 8'd0, 12'd20);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_RIGHT, 1'b0);
    set_config(8'd2, 8'd0, 12'd3);
    send_event(CMD_RIGHT, 1'b0);
    send_event(CMD_LEFT, 1'b0);
    set_config(8'd255, 8'd0, 12'd3);
    send_event(CMD_LEFT, 1'b0);
  endtask

  task automatic run_traffic(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    bit          up;
    start = events_sent;
    while (events_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n  = $urandom_range(1, 24);
        up = $urandom_range(0, 1);
        repeat (n) begin
          if (($urandom_range(0, 3) != 0) == up) send_event(CMD_RIGHT, 1'($urandom()));
          else send_event(CMD_LEFT, 1'($urandom()));
        end
      end else if (pick < 60) begin
        send_event(CMD_SHORT, 1'($urandom()));
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 4))
            0, 1:    send_event(CMD_LEFT, 1'($urandom()));
            2, 3:    send_event(CMD_RIGHT, 1'($urandom()));
            default: send_event(CMD_LONG, 1'($urandom()));
          endcase
        end
        send_event(CMD_SHORT, 1'($urandom()));
      end else if (pick < 72) begin
        send_event(CMD_LONG, 1'($urandom()));
      end else if (pick < 85) begin
        send_event(CMD_TEMP, 1'b1);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 5) == 0) send_event(CMD_TEMP, 1'b1);
          else send_event(CMD_W'($urandom_range(0, 3)), 1'($urandom()));
        end
        send_event(CMD_TEMP, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_event(CMD_W'($urandom_range(0, 7)), 1'($urandom()));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_config(FINE_STEP_RST, COARSE_STEP_RST, MAX_SP_RST);
    run_traffic(220);
    set_config(8'd0, 8'd255, 12'd4095);
    run_traffic(180);
    set_config(8'd255, 8'd0, 12'd0);
    run_traffic(100);
    set_config(STEP_W'($urandom()), STEP_W'($urandom()), SP_W'($urandom_range(100, 4095)));
    run_traffic(180);
    // lowered ceiling, setpoint usually left above it
    set_config(STEP_W'($urandom_range(0, 15)), STEP_W'($urandom()), SP_W'($urandom_range(0, 63)));
    run_traffic(150);
    in_gap_on = 1'b0;
    stall_on <= 1'b0;
    set_config(STEP_W'($urandom()), STEP_W'($urandom()), SP_W'($urandom()));
    run_traffic(200);
  endtask

  always @(posedge clk) begin
    if (!stall_on) begin
      stall_cnt <= 0;
      out_stall <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_cnt <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    ctrl_view_t got;
    ctrl_view_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {mode, setpoint, drive_value, drive_write, is_stopped, cursor, coarse_mode,
             is_locked};
      results_checked++;
      if (pending_views.size() == 0) begin
        log_failure($sformatf("result with no request pending: %s", format_view(got)));
      end else begin
        want = pending_views.pop_front();
        if (got !== want)
          log_failure($sformatf("result %0d expected %s, got %s", results_checked,
                                format_view(want), format_view(got)));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_views.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst      <= 1'b0;
    stall_on <= 1'b1;
    test_readout_turns();
    test_menu_start_stop();
    test_fault_lockout();
    test_setpoint_limits();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d events (%0d changed state), checked %0d results, %0d register writes.",
             events_sent, effective_events, results_checked, reg_writes);
    $display("Covered %0d compare rewrites and %0d fault reports; %0d failures.",
             compare_writes, fault_reports, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: encoder_menu_setpoint_controller.f
+incdir+src
src/emsc_pkg.sv
src/encoder_menu_setpoint_controller.sv
src/emsc_checker.sv
test/encoder_menu_setpoint_controller_tb.sv
